// File: rtl/pgsr_pkg.sv
// Package for the parity-guarded switch registers.
// Port codes, bit masks and the parity helper; no dependencies.
package pgsr_pkg;

  typedef enum logic [3:0] {
    PortSwOne   = 4'h4,
    PortSwTwo   = 4'h5,
    PortSwThree = 4'h6,
    PortVolume  = 4'h7,
    PortSwHigh  = 4'hE
  } port_e;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam logic [7:0] MASK_ONE_WR   = 8'hBC;
  localparam logic [7:0] INV_ONE       = 8'h04;
  localparam logic [7:0] MASK_TWO_WR   = 8'hAF;
  localparam logic [7:0] MASK_THREE_WR = 8'h3F;
  localparam logic [7:0] INV_THREE_WR  = 8'h08;
  localparam logic [7:0] MASK_THREE_RD = 8'h33;
  localparam logic [7:0] INV_THREE_RD  = 8'h02;
  localparam logic [7:0] PAR_BIT_LOW   = 8'h01;
  localparam logic [7:0] PAR_BIT_MID   = 8'h10;
  localparam logic [7:0] PAR_BIT_HIGH  = 8'h80;
  localparam logic [7:0] UNMAPPED_RD   = 8'hFF;

  // Set the spare bit when the byte has an even count of ones.
  function automatic logic [7:0] with_parity(logic [7:0] r, logic [7:0] pbit);
    return (^r) ? r : (r | pbit);
  endfunction

endpackage

// File: rtl/parity_guarded_switch_registers.sv
// Parity-guarded switch registers: three switch bytes and a beep volume.
// Uses pgsr_pkg for port codes, masks and the parity helper.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one bus access word:
//   req_type_i (0 read, 1 write), port_select_i and write_data_i.
//   Output channel (out_valid_o / out_stall_i) returns one word per access:
//   read_data_o, settings_changed_o and beep_volume_now_o.
//   Path: an accepted access reaches the outputs by way of the input register
//   and then the result register.
//   Throughput: one access per cycle; both stages move together whenever
//   the result register is empty or being taken.
//   The switch state is updated as an access moves from the input register
//   to the result register, so accesses see each other in order.
//   A write with even data parity or to an unmapped port changes nothing;
//   an unmapped read returns 0xFF.
//   Reset clears all switch bits, the volume and both stage valids.
//   When the receiver stalls, the result word holds and, once the input
//   register is also full, in_stall_o rises.
module parity_guarded_switch_registers (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       req_type_i,
  input  logic [3:0] port_select_i,
  input  logic [7:0] write_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic       settings_changed_o,
  output logic [1:0] beep_volume_now_o
);

  // input register
  logic       s1_valid_q;
  logic       s1_type_q;
  logic [3:0] s1_port_q;
  logic [7:0] s1_data_q;

  // switch state
  logic [7:0] bank_one_q, bank_one_d;
  logic [7:0] bank_two_q, bank_two_d;
  logic [7:0] bank_three_q, bank_three_d;
  logic [1:0] beep_q, beep_d;

  // result register
  logic       out_valid_q;
  logic [7:0] rdata_q;
  logic       changed_q;

  logic       s2_free;
  logic       s1_adv;
  logic       in_acc;
  logic [7:0] rdata_d;
  logic       changed_d;
  logic       wr_ok;

  assign s2_free    = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && s2_free;
  assign in_stall_o = s1_valid_q && !s2_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_type_q <= req_type_i;
      s1_port_q <= port_select_i;
      s1_data_q <= write_data_i;
    end
  end

  assign wr_ok = (s1_type_q == pgsr_pkg::REQ_WRITE) && (^s1_data_q);

  always_comb begin
    bank_one_d   = bank_one_q;
    bank_two_d   = bank_two_q;
    bank_three_d = bank_three_q;
    beep_d       = beep_q;
    rdata_d      = '0;
    if (s1_type_q == pgsr_pkg::REQ_WRITE) begin
      if (wr_ok) begin
        unique case (pgsr_pkg::port_e'(s1_port_q))
          pgsr_pkg::PortSwOne: begin
            bank_one_d = (bank_one_q & ~pgsr_pkg::MASK_ONE_WR)
                       | ((s1_data_q ^ pgsr_pkg::INV_ONE) & pgsr_pkg::MASK_ONE_WR);
          end
          pgsr_pkg::PortSwTwo: begin
            bank_two_d = (bank_two_q & ~pgsr_pkg::MASK_TWO_WR)
                       | (s1_data_q & pgsr_pkg::MASK_TWO_WR);
          end
          pgsr_pkg::PortSwThree: begin
            bank_three_d = (bank_three_q & ~pgsr_pkg::MASK_THREE_WR)
                         | ((s1_data_q ^ pgsr_pkg::INV_THREE_WR)
                            & pgsr_pkg::MASK_THREE_WR);
          end
          pgsr_pkg::PortVolume: begin
            bank_two_d[4] = s1_data_q[5];
            beep_d        = s1_data_q[3:2];
          end
          pgsr_pkg::PortSwHigh: begin
            bank_three_d[7] = s1_data_q[4];
          end
          default: begin
          end
        endcase
      end
    end else begin
      unique case (pgsr_pkg::port_e'(s1_port_q))
        pgsr_pkg::PortSwOne: begin
          rdata_d = pgsr_pkg::with_parity(
              (bank_one_q ^ pgsr_pkg::INV_ONE) & pgsr_pkg::MASK_ONE_WR,
              pgsr_pkg::PAR_BIT_LOW);
        end
        pgsr_pkg::PortSwTwo: begin
          rdata_d = pgsr_pkg::with_parity(bank_two_q & pgsr_pkg::MASK_TWO_WR,
                                          pgsr_pkg::PAR_BIT_MID);
        end
        pgsr_pkg::PortSwThree: begin
          rdata_d = pgsr_pkg::with_parity(
              (bank_three_q ^ pgsr_pkg::INV_THREE_RD) & pgsr_pkg::MASK_THREE_RD,
              pgsr_pkg::PAR_BIT_HIGH);
        end
        pgsr_pkg::PortVolume: begin
          rdata_d = pgsr_pkg::with_parity(
              {2'b00, bank_two_q[4], 1'b0, beep_q, 2'b00}, pgsr_pkg::PAR_BIT_HIGH);
        end
        pgsr_pkg::PortSwHigh: begin
          rdata_d = pgsr_pkg::with_parity({3'b000, bank_three_q[7], 4'h0},
                                          pgsr_pkg::PAR_BIT_HIGH);
        end
        default: begin
          rdata_d = pgsr_pkg::UNMAPPED_RD;
        end
      endcase
    end
    changed_d = (bank_one_d != bank_one_q) || (bank_two_d != bank_two_q)
             || (bank_three_d != bank_three_q) || (beep_d != beep_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_one_q   <= '0;
      bank_two_q   <= '0;
      bank_three_q <= '0;
      beep_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (s1_adv) begin
        bank_one_q   <= bank_one_d;
        bank_two_q   <= bank_two_d;
        bank_three_q <= bank_three_d;
        beep_q       <= beep_d;
      end
      if (s2_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      rdata_q   <= rdata_d;
      changed_q <= changed_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign read_data_o        = rdata_q;
  assign settings_changed_o = changed_q;
  assign beep_volume_now_o  = beep_q;

  // a change report never comes with read data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && settings_changed_o) |-> (read_data_o == 8'h00))
    else $error("change flagged with nonzero read data");

  // read bytes carry odd parity, except the unmapped pattern and write words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((^read_data_o) || (read_data_o == pgsr_pkg::UNMAPPED_RD)
                     || (read_data_o == 8'h00)))
    else $error("read data parity broken");

  // switch state moves only with an access leaving the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> ($stable(bank_one_q) && $stable(bank_two_q)
                 && $stable(bank_three_q) && $stable(beep_q)))
    else $error("switch state changed without an access");

  // input stalls only while the input register holds a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with room in the pipe");

endmodule
